// ===== rtl/cda_pkg.sv =====
// Shared types, constants and calendar helper functions for the date counter.
package cda_pkg;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   // Gregorian cycle length and the century marks inside it
   localparam logic [8:0] YEAR_CYCLE_LAST = 9'd399;
   localparam logic [8:0] CENTURY_1       = 9'd100;
   localparam logic [8:0] CENTURY_2       = 9'd200;
   localparam logic [8:0] CENTURY_3       = 9'd300;

   localparam logic [4:0] LEN_LONG       = 5'd31;
   localparam logic [4:0] LEN_SHORT      = 5'd30;
   localparam logic [4:0] LEN_FEB_LEAP   = 5'd29;
   localparam logic [4:0] LEN_FEB_COMMON = 5'd28;

   typedef logic [8:0] year_phase_type;

   // Leap test from the year's position within the 400-year cycle
   function automatic logic leap_of(input year_phase_type phase);
      logic century;
      century = (phase == CENTURY_1) || (phase == CENTURY_2) || (phase == CENTURY_3);
      return (phase[1:0] == 2'b00) && !century;
   endfunction

   function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         MONTH_FEB: len = leap ? LEN_FEB_LEAP : LEN_FEB_COMMON;
         MONTH_APR,
         MONTH_JUN,
         MONTH_SEP,
         MONTH_NOV: len = LEN_SHORT;
         default:   len = LEN_LONG;
      endcase
      return len;
   endfunction

endpackage

// ===== rtl/calendar_date_advance.sv =====
// Gregorian date counter: load a date or advance it by a day count, one month per cycle.
// Load: the request is taken in ST_IDLE, ST_REDUCE reduces the year modulo 400, then ST_FINISH posts.
// Advance: ST_IDLE adds the day count, ST_WALK steps the months, then ST_FINISH posts the result;
//   the day count is at most 65535. The single compare/subtract unit sets the rate.
// One transaction at a time; the next request is taken once the result register is loaded.
// Synchronous reset sets the date to day 1, month 1, year 0 and empties the result register.
module calendar_date_advance (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [3:0]  req_load_month,
   input  logic [4:0]  req_load_day,
   input  logic [15:0] req_load_year,
   input  logic [15:0] req_add_days,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_cur_month,
   output logic [4:0]  rsp_cur_day,
   output logic [15:0] rsp_cur_year,
   output logic        rsp_is_leap,
   output logic        rsp_is_month_end
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_WALK,
      ST_FINISH
   } state_type;

   localparam logic [16:0] CYCLE_BASE = 17'd400;
   localparam logic [2:0]  SHIFT_TOP  = 3'd7;

   state_type             state_ff, state_in;
   logic [16:0]           day_ff, day_in;
   logic [3:0]            month_ff, month_in;
   logic [15:0]           year_ff, year_in;
   cda_pkg::year_phase_type phase_ff, phase_in;
   logic [15:0]           rem_ff, rem_in;
   logic [2:0]            shift_ff, shift_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [3:0]            rsp_month_ff, rsp_month_in;
   logic [4:0]            rsp_day_ff, rsp_day_in;
   logic [15:0]           rsp_year_ff, rsp_year_in;
   logic                  rsp_leap_ff, rsp_leap_in;
   logic                  rsp_end_ff, rsp_end_in;

   logic                  leap;
   logic [4:0]            len;
   logic [16:0]           sub_a, sub_b;
   logic [17:0]           diff;
   logic                  sub_ge, sub_zero;
   logic                  req_take, rsp_free;
   logic [3:0]            ld_month;
   logic [4:0]            ld_day;

   assign leap = cda_pkg::leap_of(phase_ff);
   assign len  = cda_pkg::month_length(month_ff, leap);

   // Shared compare/subtract: year reduction while loading, month walk otherwise
   always_comb begin
      if (state_ff == ST_REDUCE) begin
         sub_a = {1'b0, rem_ff};
         sub_b = CYCLE_BASE << shift_ff;
      end else begin
         sub_a = day_ff;
         sub_b = {12'd0, len};
      end
   end

   assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge   = !diff[17];
   assign sub_zero = (diff == 18'd0);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      ld_month = req_load_month;
      if (ld_month == 4'd0) ld_month = cda_pkg::MONTH_JAN;
      if (ld_month > cda_pkg::MONTH_DEC) ld_month = cda_pkg::MONTH_DEC;
      ld_day = (req_load_day == 5'd0) ? 5'd1 : req_load_day;
   end

   always_comb begin
      state_in     = state_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      phase_in     = phase_ff;
      rem_in       = rem_ff;
      shift_in     = shift_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_month_in = rsp_month_ff;
      rsp_day_in   = rsp_day_ff;
      rsp_year_in  = rsp_year_ff;
      rsp_leap_in  = rsp_leap_ff;
      rsp_end_in   = rsp_end_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_cmd == cda_pkg::CMD_LOAD) begin
                  month_in = ld_month;
                  day_in   = {12'd0, ld_day};
                  year_in  = req_load_year;
                  rem_in   = req_load_year;
                  shift_in = SHIFT_TOP;
                  state_in = ST_REDUCE;
               end else begin
                  day_in   = day_ff + {1'b0, req_add_days};
                  state_in = ST_WALK;
               end
            end
         end
         ST_REDUCE: begin
            if (sub_ge) rem_in = diff[15:0];
            shift_in = shift_ff - 3'd1;
            if (shift_ff == 3'd0) begin
               phase_in = sub_ge ? diff[8:0] : rem_ff[8:0];
               state_in = ST_FINISH;
            end
         end
         ST_WALK: begin
            if (sub_ge && !sub_zero) begin
               day_in = diff[16:0];
               if (month_ff >= cda_pkg::MONTH_DEC) begin
                  month_in = cda_pkg::MONTH_JAN;
                  year_in  = year_ff + 16'd1;
                  // keep the 400-year phase in step; the 16-bit wrap lands on year 0
                  if (year_ff == 16'hFFFF || phase_ff == cda_pkg::YEAR_CYCLE_LAST) begin
                     phase_in = '0;
                  end else begin
                     phase_in = phase_ff + 9'd1;
                  end
               end else begin
                  month_in = month_ff + 4'd1;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the result register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_month_in = month_ff;
               rsp_day_in   = day_ff[4:0];
               rsp_year_in  = year_ff;
               rsp_leap_in  = leap;
               rsp_end_in   = sub_zero;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         day_ff       <= 17'd1;
         month_ff     <= cda_pkg::MONTH_JAN;
         year_ff      <= 16'd0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         day_ff       <= day_in;
         month_ff     <= month_in;
         year_ff      <= year_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff       <= rem_in;
      shift_ff     <= shift_in;
      rsp_month_ff <= rsp_month_in;
      rsp_day_ff   <= rsp_day_in;
      rsp_year_ff  <= rsp_year_in;
      rsp_leap_ff  <= rsp_leap_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cur_month    = rsp_month_ff;
   assign rsp_cur_day      = rsp_day_ff;
   assign rsp_cur_year     = rsp_year_ff;
   assign rsp_is_leap      = rsp_leap_ff;
   assign rsp_is_month_end = rsp_end_ff;

endmodule
